[src/sem_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int PIX_W      = 8;
  localparam int MAG_W      = 8;
  localparam int ROW_W      = 12;
  localparam int OCOL_W     = 10;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 20;
  localparam int ENERGY_W   = 21;
  localparam int RAD_W      = 16;
  localparam int REM_W      = 11;
  localparam int ROOT_STEPS = 8;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  localparam logic [MAG_W-1:0]   MAG_MAX     = 8'd255;
  localparam logic [IMG_H_W-1:0] MIN_DIM_H   = 13'd3;
  localparam logic [IMG_H_W-1:0] MAX_HEIGHT  = 13'd4096;
  localparam logic [IMG_W_W-1:0] RST_WIDTH   = 11'd1024;
  localparam logic [IMG_H_W-1:0] RST_HEIGHT  = 13'd1024;

  // Configuration register indexes.
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  typedef struct packed {
    logic load;    // latch pixel, fetch line stores, advance counters
    logic window;  // shift window and write back line stores
    logic grad;    // register Gx and Gy
    logic square;  // register squared gradients
    logic sum;     // register energy and start the square root
    logic step;    // one square root step
    logic emit;    // load the output register
  } sem_cmd_t;

  typedef struct packed {
    logic interior;  // current pixel completes an interior window
    logic out_free;  // output register can take a result this cycle
  } sem_status_t;

endpackage : sem_pkg
`default_nettype wire

[src/sem_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_ctrl
// Sequencer for one pixel at a time: fetch, gradient, square, root, emit.
// ----------------------------------------------------------------------------
module sem_ctrl
  import sem_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          in_valid,
  output logic         in_ready,
  input  sem_status_t  status,
  output sem_cmd_t     cmd
);

  typedef enum logic [2:0] {
    IDLE,
    FETCH,
    GRAD,
    SQUARE,
    SUM,
    ROOT,
    EMIT
  } state_t;

  state_t              state;
  logic [STEP_W-1:0]   step_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      step_cnt <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= FETCH;
          end
        end
        FETCH: begin
          state <= status.interior ? GRAD : IDLE;
        end
        GRAD:   state <= SQUARE;
        SQUARE: state <= SUM;
        SUM: begin
          state    <= ROOT;
          step_cnt <= '0;
        end
        ROOT: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == STEP_W'(ROOT_STEPS - 1)) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (status.out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready   = (state == IDLE);
    cmd        = '0;
    cmd.load   = (state == IDLE) && in_valid;
    cmd.window = (state == FETCH);
    cmd.grad   = (state == GRAD);
    cmd.square = (state == SQUARE);
    cmd.sum    = (state == SUM);
    cmd.step   = (state == ROOT);
    cmd.emit   = (state == EMIT) && status.out_free;
  end

endmodule : sem_ctrl
`default_nettype wire

[src/sem_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_dp
// Line stores, 3x3 window, position counters, gradient and square root
// datapath, and the output register.
// ----------------------------------------------------------------------------
module sem_dp
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = $clog2(MAX_WIDTH),
  parameter int CMPW      = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W
) (
  input  wire                 clk,
  input  wire                 rst,
  input  sem_cmd_t            cmd,
  output sem_status_t         status,
  input  wire  [CMPW-1:0]     eff_width,
  input  wire  [IMG_H_W-1:0]  eff_height,
  input  wire  [PIX_W-1:0]    in_pixel,
  input  wire                 in_frame_start,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [MAG_W-1:0]    out_magnitude,
  output logic [ROW_W-1:0]    out_row,
  output logic [OCOL_W-1:0]   out_col,
  output logic                out_last
);

  localparam int XW = (CW > OCOL_W) ? CW : OCOL_W;

  logic [PIX_W-1:0]  line_store_upper  [MAX_WIDTH];
  logic [PIX_W-1:0]  line_store_middle [MAX_WIDTH];

  logic [CW-1:0]     col_count;
  logic [ROW_W-1:0]  row_count;
  logic [CW-1:0]     cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [PIX_W-1:0]  cur_pix;
  logic [PIX_W-1:0]  rd_upper;
  logic [PIX_W-1:0]  rd_middle;

  logic [CW-1:0]     col_sel;
  logic [ROW_W-1:0]  row_sel;
  logic [CW-1:0]     col_next;
  logic [ROW_W-1:0]  row_next;
  logic              col_wrap;

  // win[row][col]: row 0 is top, col 2 is the newest column.
  logic [PIX_W-1:0]  win [3][3];

  logic signed [GRAD_W-1:0]     gx;
  logic signed [GRAD_W-1:0]     gy;
  logic [SQ_W-1:0]              sq_x;
  logic [SQ_W-1:0]              sq_y;
  logic [RAD_W-1:0]             rad;
  logic                         big;
  logic [REM_W-1:0]             rem;
  logic [MAG_W-1:0]             root;

  logic [GRAD_W-2:0]            gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [2*GRAD_W-1:0]   prod_x, prod_y;
  logic [ENERGY_W-1:0]          energy;
  logic [REM_W-1:0]             rem_sh;
  logic [REM_W-1:0]             trial;

  logic [CMPW-1:0]   col_x;
  logic [IMG_H_W-1:0] row_x;
  logic [XW-1:0]     col_m1;
  logic              last_px;

  // Frame start restarts the position before this pixel is placed.
  assign col_sel  = in_frame_start ? '0 : col_count;
  assign row_sel  = in_frame_start ? '0 : row_count;
  assign col_wrap = (CMPW'(col_sel) + 1'b1) >= eff_width;

  always_comb begin
    col_next = col_sel + 1'b1;
    row_next = row_sel;
    if (col_wrap) begin
      col_next = '0;
      if ((IMG_H_W'(row_sel) + 1'b1) >= eff_height) begin
        row_next = '0;
      end else begin
        row_next = row_sel + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cmd.load) begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_col   <= col_sel;
      cur_row   <= row_sel;
      cur_pix   <= in_pixel;
      rd_upper  <= line_store_upper[col_sel];
      rd_middle <= line_store_middle[col_sel];
    end
    if (cmd.window) begin
      line_store_upper[cur_col]  <= rd_middle;
      line_store_middle[cur_col] <= cur_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win[k][j] <= '0;
        end
      end
    end else if (cmd.window) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= rd_upper;
      win[1][2] <= rd_middle;
      win[2][2] <= cur_pix;
    end
  end

  assign col_x   = CMPW'(cur_col);
  assign row_x   = IMG_H_W'(cur_row);
  assign last_px = ((row_x + 1'b1) == eff_height) && ((col_x + 1'b1) == eff_width);

  // Evaluated while the window shifts in the newest column.
  assign status.interior = (cur_row >= ROW_W'(2)) && (cur_col >= CW'(2)) &&
                           (row_x < eff_height) && (col_x < eff_width);
  assign status.out_free = !out_valid || out_ready;

  // Sobel kernels; the center weights are 2, done as a one-bit shift.
  assign gx_pos = (GRAD_W-1)'(win[0][2]) + {1'b0, win[1][2], 1'b0} + (GRAD_W-1)'(win[2][2]);
  assign gx_neg = (GRAD_W-1)'(win[0][0]) + {1'b0, win[1][0], 1'b0} + (GRAD_W-1)'(win[2][0]);
  assign gy_pos = (GRAD_W-1)'(win[2][0]) + {1'b0, win[2][1], 1'b0} + (GRAD_W-1)'(win[2][2]);
  assign gy_neg = (GRAD_W-1)'(win[0][0]) + {1'b0, win[0][1], 1'b0} + (GRAD_W-1)'(win[0][2]);

  assign prod_x = gx * gx;
  assign prod_y = gy * gy;
  assign energy = ENERGY_W'(sq_x) + ENERGY_W'(sq_y);

  // One result bit per step, two radicand bits shifted in each time.
  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      gx <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
      gy <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    end
    if (cmd.square) begin
      sq_x <= prod_x[SQ_W-1:0];
      sq_y <= prod_y[SQ_W-1:0];
    end
    if (cmd.sum) begin
      rad  <= energy[RAD_W-1:0];
      big  <= |energy[ENERGY_W-1:RAD_W];
      rem  <= '0;
      root <= '0;
    end else if (cmd.step) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[MAG_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign col_m1 = XW'(cur_col) - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_magnitude <= big ? MAG_MAX : root;
      out_row       <= cur_row - 1'b1;
      out_col       <= col_m1[OCOL_W-1:0];
      out_last      <= last_px;
    end
  end

endmodule : sem_dp
`default_nettype wire

[src/sobel_edge_magnitude.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Sobel 3x3 gradient magnitude over a raster pixel stream, with configurable
// frame size, two line stores and a bit-serial integer square root.
// ----------------------------------------------------------------------------
// An interior pixel goes through fetch, gradient, square, sum, the 8-step
// square root and emit, which waits for a free output register; a border
// pixel ends after fetch. A new pixel is taken only once the last is done,
// and the next is taken while a finished result waits at the output.
// Reset: counters, window and control clear at once; line stores hold
// whatever they held and are valid once written during the frame.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [7:0]   s_axis_tdata,   // [7:0] pixel
  input  wire          s_axis_tuser,   // [0] frame_start
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [31:0]  m_axis_tdata,   // [7:0] magnitude, [19:8] center_row,
                                       // [29:20] center_col, [31:30] zero
  output logic         m_axis_tlast,   // frame_last
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire          cfg_index,
  input  wire  [12:0]  cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;

  logic [IMG_W_W-1:0]  image_width;
  logic [IMG_H_W-1:0]  image_height;
  logic [CMPW-1:0]     width_x;
  logic [CMPW-1:0]     eff_width;
  logic [IMG_H_W-1:0]  eff_height;

  sem_cmd_t            cmd;
  sem_status_t         status;
  logic [MAG_W-1:0]    magnitude;
  logic [ROW_W-1:0]    center_row;
  logic [OCOL_W-1:0]   center_col;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_WIDTH;
      image_height <= RST_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  image_width  <= cfg_data[IMG_W_W-1:0];
        CFG_IDX_HEIGHT: image_height <= cfg_data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range sizes are clamped to what the line stores and counters hold.
  assign width_x = CMPW'(image_width);

  always_comb begin
    if (width_x < CMPW'(3)) begin
      eff_width = CMPW'(3);
    end else if (width_x > CMPW'(MAX_WIDTH)) begin
      eff_width = CMPW'(MAX_WIDTH);
    end else begin
      eff_width = width_x;
    end
    if (image_height < MIN_DIM_H) begin
      eff_height = MIN_DIM_H;
    end else if (image_height > MAX_HEIGHT) begin
      eff_height = MAX_HEIGHT;
    end else begin
      eff_height = image_height;
    end
  end

  sem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sem_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW),
    .CMPW      (CMPW)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .eff_width      (eff_width),
    .eff_height     (eff_height),
    .in_pixel       (s_axis_tdata),
    .in_frame_start (s_axis_tuser),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_magnitude  (magnitude),
    .out_row        (center_row),
    .out_col        (center_col),
    .out_last       (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, center_col, center_row, magnitude};

  // A pixel transaction always starts a multi-cycle sequence.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready stayed high after a pixel transaction");

  // Results belong to interior rows only.
  a_row_interior: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (center_row != '0))
    else $error("result on the top border row");

  // The padding bits of the result word stay clear.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[31:30] == 2'b00))
    else $error("result padding bits set");

endmodule : sobel_edge_magnitude
`default_nettype wire

[test/sobel_magnitude_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_magnitude_checker
// Watches the pixel, result and register channels of the Sobel edge magnitude
// block. It keeps its own line stores, window and frame counters, predicts
// the magnitude, position and last flag of each interior pixel, and compares
// every result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module sobel_magnitude_checker
  import sem_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,
  input  wire         s_axis_tuser,
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire  [31:0] m_axis_tdata,
  input  wire         m_axis_tlast,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire         cfg_index,
  input  wire  [12:0] cfg_data,
  output int          mismatch_count,
  output int          pending_count,
  output int          checked_count
);

  localparam int LINE_DEPTH = 1024;
  localparam int MAX_ROWS   = 4096;

  typedef struct packed {
    logic [MAG_W-1:0]  magnitude;
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic              last;
  } edge_result_t;

  logic [PIX_W-1:0]   upper_line  [LINE_DEPTH];
  logic [PIX_W-1:0]   middle_line [LINE_DEPTH];
  logic [PIX_W-1:0]   win [3][3];
  logic [IMG_W_W-1:0] width_reg;
  logic [IMG_H_W-1:0] height_reg;
  int unsigned        col_pos;
  int unsigned        row_pos;
  edge_result_t       expected_edges [$];
  int                 errors;
  int                 checked;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo,
                                            int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Greedy bit-by-bit root: keep each bit whose square still fits.
  function automatic int unsigned floor_sqrt(int unsigned energy);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int b = 11; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= energy) root = trial;
    end
    return root;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
    errors++;
    if (errors <= 10)
      $display("[%0t] %s: expected %0d, got %0d", $time, what, exp_v, act_v);
  endtask

  task predict_magnitude(input logic [PIX_W-1:0] px, input logic frame_start);
    int unsigned  w, h, r, c, mag;
    logic [7:0]   up, mid;
    int           tl, tm, tr, ml, mr, bl, bm, br, gx, gy;
    edge_result_t res;
    w = clamp_dim(width_reg, 3, LINE_DEPTH);
    h = clamp_dim(height_reg, 3, MAX_ROWS);
    if (frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    up = '0;
    mid = '0;
    if (c < LINE_DEPTH) begin
      up = upper_line[c];
      mid = middle_line[c];
      upper_line[c] = mid;
      middle_line[c] = px;
    end
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = px;

    if (r >= 2 && c >= 2 && r < h && c < w) begin
      tl = win[0][0]; tm = win[0][1]; tr = win[0][2];
      ml = win[1][0]; mr = win[1][2];
      bl = win[2][0]; bm = win[2][1]; br = win[2][2];
      gx = (tr + 2 * mr + br) - (tl + 2 * ml + bl);
      gy = (bl + 2 * bm + br) - (tl + 2 * tm + tr);
      mag = floor_sqrt(gx * gx + gy * gy);
      if (mag > MAG_MAX) mag = MAG_MAX;
      res.magnitude = MAG_W'(mag);
      res.row = ROW_W'(r - 1);
      res.col = OCOL_W'(c - 1);
      res.last = (r == h - 1) && (c == w - 1);
      expected_edges.insert(expected_edges.size(), res);
    end

    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk) begin
    edge_result_t want;
    if (rst) begin
      width_reg = RST_WIDTH;
      height_reg = RST_HEIGHT;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      for (int k = 0; k < 9; k++) win[k / 3][k % 3] = '0;
      col_pos = 0;
      row_pos = 0;
      expected_edges.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDX_WIDTH) width_reg = cfg_data[IMG_W_W-1:0];
        else height_reg = cfg_data[IMG_H_W-1:0];
      end

      // Results are taken before new pixels; no result can stem from a
      // pixel accepted at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_edges.size() == 0) begin
          report_mismatch("result with nothing pending, magnitude", '0,
                          m_axis_tdata[7:0]);
        end else begin
          want = expected_edges.pop_front();
          checked++;
          if (m_axis_tdata[7:0] !== want.magnitude)
            report_mismatch("magnitude", want.magnitude, m_axis_tdata[7:0]);
          if (m_axis_tdata[19:8] !== want.row)
            report_mismatch("center_row", want.row, m_axis_tdata[19:8]);
          if (m_axis_tdata[29:20] !== want.col)
            report_mismatch("center_col", want.col, m_axis_tdata[29:20]);
          if (m_axis_tlast !== want.last)
            report_mismatch("frame_last", want.last, m_axis_tlast);
        end
      end

      if (s_axis_tvalid && s_axis_tready)
        predict_magnitude(s_axis_tdata, s_axis_tuser);
    end
    mismatch_count <= errors;
    pending_count <= expected_edges.size();
    checked_count <= checked;
  end

endmodule

[test/tb_sobel_edge_magnitude.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude
// Drives pixel frames of many sizes into the Sobel edge magnitude block, with
// bursty input and a stalling output side, and lets the checker compare every
// result against its own prediction.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude;
  import sem_pkg::*;

  localparam int SETTLE_CYCLES = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] pixel
  logic        s_axis_tuser = 1'b0;  // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [7:0] magnitude, [19:8] center_row,
                                     // [29:20] center_col, [31:30] zero
  logic        m_axis_tlast;         // frame_last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_IDX_WIDTH;
  logic [12:0] cfg_data = '0;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int burst_left = 0;
  int pixels_sent = 0;
  int settings_used = 0;
  int stall_mode = 0;
  int stall_left = 0;

  sobel_edge_magnitude dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  sobel_magnitude_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // The output side switches between always ready, mostly ready, mostly
  // stalled and a long periodic stall.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        m_axis_tready <= ((stall_left % 16) < 4);
      end
    endcase
  end

  function automatic logic [7:0] random_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int effective_dim(int v, int hi);
    return (v < 3) ? 3 : ((v > hi) ? hi : v);
  endfunction

  task send_pixel(input logic [7:0] px, input logic frame_start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 16);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    s_axis_tuser <= frame_start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pixels_sent++;
  endtask

  task wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Border pixels give no result, so the block may still be busy once the
  // last result is out; hold off past its latency before touching registers.
  task program_frame(input logic [12:0] width_val, input logic [12:0] height_val);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_WIDTH;
    cfg_data <= width_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_IDX_HEIGHT;
    cfg_data <= height_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Random frames; the first pixel always restarts the counts so no line
  // store entry from an older frame size ever enters a result.
  task automatic run_frames(input int items, input int w, input int h,
                            input bit noisy);
    int   pos;
    logic mark;
    pos = 0;
    for (int i = 0; i < items; i++) begin
      if (i == 0) mark = 1'b1;
      else if (pos == 0) mark = ($urandom_range(0, 3) != 0);
      else mark = noisy && ($urandom_range(0, 59) == 0);
      if (mark) pos = 0;
      if (noisy && $urandom_range(0, 149) == 0) wait_for_results();
      send_pixel(random_pixel(), mark);
      pos = (pos + 1) % (w * h);
    end
  endtask

  initial begin
    logic [12:0] width_val;
    logic [12:0] height_val;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed 3x3 frames: hard vertical edge (clamps), a flat frame that
    // follows without a start mark, a cut-short frame, then a ramp.
    program_frame(13'd3, 13'd3);
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? 8'd255 : 8'd0, i == 0);
    for (int i = 0; i < 9; i++) send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    for (int i = 0; i < 9; i++) send_pixel(8'(10 * (i + 1)), i == 0);
    wait_for_results();

    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(0, 5))
        0: width_val = $urandom_range(0, 2);
        1: width_val = {2'($urandom_range(1, 3)), 11'($urandom_range(3, 9))};
        default: width_val = $urandom_range(3, 10);
      endcase
      height_val = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2)
                                               : $urandom_range(3, 7);
      program_frame(width_val, height_val);
      run_frames(100, effective_dim(width_val & 13'h7FF, 1024),
                 effective_dim(height_val, 4096), 1'b1);
    end

    // Size extremes: the top rows of the narrowest frame at full height,
    // then the start of the first row of the widest frame.
    program_frame(13'd0, 13'h1FFF);
    run_frames(60, 3, 4096, 1'b0);
    program_frame(13'h1FFF, 13'd0);
    run_frames(30, 1024, 3, 1'b0);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d pixels under %0d frame sizes, from 3x3 to the clamped limits.",
             pixels_sent, settings_used);
    $display("%0d edge magnitudes were compared with their predictions.", checked_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
src/sem_pkg.sv
src/sem_ctrl.sv
src/sem_dp.sv
src/sobel_edge_magnitude.sv
test/sobel_magnitude_checker.sv
test/tb_sobel_edge_magnitude.sv
